@@ rtl/source_token_scanner_defines.svh @@
// Assertion helpers shared by the scanner checkers.
`ifndef SOURCE_TOKEN_SCANNER_DEFINES_SVH
`define SOURCE_TOKEN_SCANNER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define STS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sts_pkg.sv @@
package sts_pkg;

	localparam int OUT_W = 16;

	typedef logic [4:0] kind_t;
	typedef logic [3:0] cls_t;

	// Byte classes
	localparam cls_t C_PUNCT   = 4'd0;
	localparam cls_t C_DOT     = 4'd1;
	localparam cls_t C_SLASH   = 4'd2;
	localparam cls_t C_EQ      = 4'd3;
	localparam cls_t C_LT      = 4'd4;
	localparam cls_t C_GT      = 4'd5;
	localparam cls_t C_BANG    = 4'd6;
	localparam cls_t C_QUOTE   = 4'd7;
	localparam cls_t C_SPACE   = 4'd8;
	localparam cls_t C_NEWLINE = 4'd9;
	localparam cls_t C_DIGIT   = 4'd10;
	localparam cls_t C_ALPHA   = 4'd11;
	localparam cls_t C_UNDER   = 4'd12;
	localparam cls_t C_OTHER   = 4'd13;

	// Token kinds
	localparam kind_t K_LPAREN   = 5'd0;
	localparam kind_t K_RPAREN   = 5'd1;
	localparam kind_t K_LBRACE   = 5'd2;
	localparam kind_t K_RBRACE   = 5'd3;
	localparam kind_t K_STAR     = 5'd4;
	localparam kind_t K_PLUS     = 5'd5;
	localparam kind_t K_MINUS    = 5'd6;
	localparam kind_t K_DOT      = 5'd7;
	localparam kind_t K_COMMA    = 5'd8;
	localparam kind_t K_SEMI     = 5'd9;
	localparam kind_t K_SLASH    = 5'd10;
	localparam kind_t K_COMMENT  = 5'd11;
	localparam kind_t K_EQ       = 5'd12;
	localparam kind_t K_EQ_EQ    = 5'd13;
	localparam kind_t K_LT       = 5'd14;
	localparam kind_t K_LT_EQ    = 5'd15;
	localparam kind_t K_GT       = 5'd16;
	localparam kind_t K_GT_EQ    = 5'd17;
	localparam kind_t K_BANG     = 5'd18;
	localparam kind_t K_BANG_EQ  = 5'd19;
	localparam kind_t K_STRING   = 5'd20;
	localparam kind_t K_INT      = 5'd21;
	localparam kind_t K_FLOAT    = 5'd22;
	localparam kind_t K_IDENT    = 5'd23;
	localparam kind_t K_BAD      = 5'd24;
	localparam kind_t K_UNTERM   = 5'd25;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       end_of_source;
	} in_t;

	typedef struct packed {
		kind_t            token_kind;
		logic [OUT_W-1:0] token_line;
		logic [OUT_W-1:0] token_column;
		logic [OUT_W-1:0] token_length;
		logic             last_of_run;
	} out_t;

	// Classified byte as it travels from front to back
	typedef struct packed {
		cls_t  cls;
		kind_t punct_kind;
		logic  last;
	} item_t;

endpackage

@@ rtl/sts_fifo.sv @@
module sts_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr0,
	input  logic [WIDTH-1:0]           wdata0,
	input  logic                       wr1,
	input  logic [WIDTH-1:0]           wdata1,
	input  logic                       rd,
	output logic [WIDTH-1:0]           rdata,
	output logic                       empty,
	output logic [$clog2(DEPTH+1)-1:0] free
);

	// DEPTH is a power of two; wr1 is only used together with wr0.
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wp_q;
	logic [AW-1:0]    rp_q;
	logic [CW-1:0]    cnt_q;

	always_ff @(posedge clk) begin
		if (wr0) begin
			mem_q[wp_q] <= wdata0;
		end
		if (wr1) begin
			mem_q[wp_q + AW'(1)] <= wdata1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + AW'(wr0) + AW'(wr1);
			rp_q  <= rp_q + AW'(rd);
			cnt_q <= cnt_q + CW'(wr0) + CW'(wr1) - CW'(rd);
		end
	end

	assign rdata = mem_q[rp_q];
	assign empty = (cnt_q == '0);
	assign free  = CW'(DEPTH) - cnt_q;

endmodule

@@ rtl/sts_front.sv @@
module sts_front (
	input  logic          in_valid,
	output logic          in_ready,
	input  sts_pkg::in_t  in_data,
	input  logic          queue_has_room,
	output logic          push,
	output sts_pkg::item_t item
);

	import sts_pkg::*;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_RBRC  = 8'h7D;

	assign in_ready = queue_has_room;
	assign push     = in_valid && queue_has_room;

	always_comb begin
		item.last       = in_data.end_of_source;
		item.punct_kind = K_BAD;
		unique case (in_data.source_byte) inside
			CH_LPAR: begin item.cls = C_PUNCT; item.punct_kind = K_LPAREN; end
			CH_RPAR: begin item.cls = C_PUNCT; item.punct_kind = K_RPAREN; end
			CH_LBRC: begin item.cls = C_PUNCT; item.punct_kind = K_LBRACE; end
			CH_RBRC: begin item.cls = C_PUNCT; item.punct_kind = K_RBRACE; end
			CH_STAR: begin item.cls = C_PUNCT; item.punct_kind = K_STAR; end
			CH_PLUS: begin item.cls = C_PUNCT; item.punct_kind = K_PLUS; end
			CH_MINUS: begin item.cls = C_PUNCT; item.punct_kind = K_MINUS; end
			CH_COMMA: begin item.cls = C_PUNCT; item.punct_kind = K_COMMA; end
			CH_SEMI: begin item.cls = C_PUNCT; item.punct_kind = K_SEMI; end
			CH_DOT: begin item.cls = C_DOT; item.punct_kind = K_DOT; end
			CH_SLASH: item.cls = C_SLASH;
			CH_EQ: item.cls = C_EQ;
			CH_LT: item.cls = C_LT;
			CH_GT: item.cls = C_GT;
			CH_BANG: item.cls = C_BANG;
			CH_QUOTE: item.cls = C_QUOTE;
			CH_SPACE, CH_TAB, CH_CR: item.cls = C_SPACE;
			CH_LF: item.cls = C_NEWLINE;
			CH_UNDER: item.cls = C_UNDER;
			[8'h30:8'h39]: item.cls = C_DIGIT;
			[8'h41:8'h5A], [8'h61:8'h7A]: item.cls = C_ALPHA;
			default: item.cls = C_OTHER;
		endcase
	end

endmodule

@@ rtl/sts_back.sv @@
module sts_back #(
	parameter int POSITION_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  sts_pkg::item_t item,
	input  logic           item_valid,
	output logic           item_pop,
	input  logic           tok_room,
	output logic           tok_wr0,
	output sts_pkg::out_t  tok0,
	output logic           tok_wr1,
	output sts_pkg::out_t  tok1
);

	import sts_pkg::*;

	typedef logic [POSITION_BITS-1:0] pos_t;

	localparam int EXT_W = (POSITION_BITS > OUT_W) ? POSITION_BITS : OUT_W;

	localparam logic [3:0] M_IDLE    = 4'd0;
	localparam logic [3:0] M_SLASH   = 4'd1;
	localparam logic [3:0] M_EQ      = 4'd2;
	localparam logic [3:0] M_LT      = 4'd3;
	localparam logic [3:0] M_GT      = 4'd4;
	localparam logic [3:0] M_BANG    = 4'd5;
	localparam logic [3:0] M_COMMENT = 4'd6;
	localparam logic [3:0] M_STRING  = 4'd7;
	localparam logic [3:0] M_INT     = 4'd8;
	localparam logic [3:0] M_FLOAT   = 4'd9;
	localparam logic [3:0] M_IDENT   = 4'd10;

	function automatic pos_t sat_inc(input pos_t v);
		return (v == {POSITION_BITS{1'b1}}) ? v : v + pos_t'(1);
	endfunction

	function automatic logic [OUT_W-1:0] clamp_out(input pos_t v);
		logic [EXT_W-1:0] e;
		e = EXT_W'(v);
		return (e > EXT_W'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : e[OUT_W-1:0];
	endfunction

	function automatic kind_t cmp_kind(input logic [3:0] mode, input logic with_eq);
		kind_t k;
		unique case (mode)
			M_EQ: k = with_eq ? K_EQ_EQ : K_EQ;
			M_LT: k = with_eq ? K_LT_EQ : K_LT;
			M_GT: k = with_eq ? K_GT_EQ : K_GT;
			default: k = with_eq ? K_BANG_EQ : K_BANG;
		endcase
		return k;
	endfunction

	logic [3:0] mode_q;
	pos_t       line_q;
	pos_t       col_q;
	pos_t       start_line_q;
	pos_t       start_col_q;
	pos_t       len_q;

	logic       is_nl;
	pos_t       col_inc;
	logic       rescan;
	logic [3:0] mode_a;
	pos_t       len_a;
	logic       e0_v;
	kind_t      e0_kind;
	pos_t       e0_len;
	logic [3:0] mode_b;
	pos_t       len_b;
	pos_t       start_line_b;
	pos_t       start_col_b;
	logic       e1_v;
	kind_t      e1_kind;
	logic       e2_v;
	kind_t      e2_kind;
	pos_t       e2_len;
	logic       tb_v;
	kind_t      tb_kind;
	pos_t       tb_len;
	logic [3:0] mode_n;
	pos_t       line_n;
	pos_t       col_n;
	pos_t       start_line_n;
	pos_t       start_col_n;
	pos_t       len_n;
	out_t       tok_a;
	out_t       tok_b;

	assign item_pop = item_valid && tok_room;
	assign is_nl    = (item.cls == C_NEWLINE);

	always_comb begin
		col_inc = is_nl ? col_q : sat_inc(col_q);

		// Resolve the pending lexeme against this byte
		e0_v    = 1'b0;
		e0_kind = K_BAD;
		e0_len  = len_q;
		rescan  = 1'b0;
		mode_a  = mode_q;
		len_a   = len_q;
		unique case (mode_q) inside
			M_SLASH: begin
				if (item.cls == C_SLASH) begin
					mode_a = M_COMMENT;
					len_a  = pos_t'(2);
				end else begin
					e0_v    = 1'b1;
					e0_kind = K_SLASH;
					e0_len  = pos_t'(1);
					rescan  = 1'b1;
				end
			end
			M_EQ, M_LT, M_GT, M_BANG: begin
				e0_v = 1'b1;
				if (item.cls == C_EQ) begin
					e0_kind = cmp_kind(mode_q, 1'b1);
					e0_len  = pos_t'(2);
					mode_a  = M_IDLE;
				end else begin
					e0_kind = cmp_kind(mode_q, 1'b0);
					e0_len  = pos_t'(1);
					rescan  = 1'b1;
				end
			end
			M_COMMENT: begin
				if (is_nl) begin
					e0_v    = 1'b1;
					e0_kind = K_COMMENT;
					mode_a  = M_IDLE;
				end else begin
					len_a = sat_inc(len_q);
				end
			end
			M_STRING: begin
				len_a  = sat_inc(len_q);
				e0_len = len_a;
				if (item.cls == C_QUOTE) begin
					e0_v    = 1'b1;
					e0_kind = K_STRING;
					mode_a  = M_IDLE;
				end
			end
			M_INT: begin
				if (item.cls == C_DIGIT || item.cls == C_UNDER) begin
					len_a = sat_inc(len_q);
				end else if (item.cls == C_DOT) begin
					len_a  = sat_inc(len_q);
					mode_a = M_FLOAT;
				end else begin
					e0_v    = 1'b1;
					e0_kind = K_INT;
					rescan  = 1'b1;
				end
			end
			M_FLOAT: begin
				if (item.cls == C_DIGIT) begin
					len_a = sat_inc(len_q);
				end else begin
					e0_v    = 1'b1;
					e0_kind = K_FLOAT;
					rescan  = 1'b1;
				end
			end
			M_IDENT: begin
				if (item.cls == C_DIGIT || item.cls == C_ALPHA) begin
					len_a = sat_inc(len_q);
				end else begin
					e0_v    = 1'b1;
					e0_kind = K_IDENT;
					rescan  = 1'b1;
				end
			end
			default: rescan = 1'b1;
		endcase

		// Start a new lexeme with this byte
		mode_b       = mode_a;
		len_b        = len_a;
		start_line_b = start_line_q;
		start_col_b  = start_col_q;
		e1_v         = 1'b0;
		e1_kind      = K_BAD;
		if (rescan) begin
			mode_b       = M_IDLE;
			len_b        = pos_t'(1);
			start_line_b = line_q;
			start_col_b  = col_inc;
			unique case (item.cls) inside
				C_PUNCT, C_DOT: begin
					e1_v    = 1'b1;
					e1_kind = item.punct_kind;
				end
				C_SLASH: mode_b = M_SLASH;
				C_EQ: mode_b = M_EQ;
				C_LT: mode_b = M_LT;
				C_GT: mode_b = M_GT;
				C_BANG: mode_b = M_BANG;
				C_QUOTE: mode_b = M_STRING;
				C_DIGIT: mode_b = M_INT;
				C_ALPHA: mode_b = M_IDENT;
				C_SPACE, C_NEWLINE: mode_b = M_IDLE;
				default: e1_v = 1'b1;
			endcase
		end

		// Flush whatever is still pending on the final byte
		e2_v    = 1'b0;
		e2_kind = K_BAD;
		e2_len  = len_b;
		if (item.last) begin
			unique case (mode_b) inside
				M_SLASH: begin
					e2_v    = 1'b1;
					e2_kind = K_SLASH;
					e2_len  = pos_t'(1);
				end
				M_EQ, M_LT, M_GT, M_BANG: begin
					e2_v    = 1'b1;
					e2_kind = cmp_kind(mode_b, 1'b0);
					e2_len  = pos_t'(1);
				end
				M_COMMENT: begin e2_v = 1'b1; e2_kind = K_COMMENT; end
				M_STRING: begin e2_v = 1'b1; e2_kind = K_UNTERM; end
				M_INT: begin e2_v = 1'b1; e2_kind = K_INT; end
				M_FLOAT: begin e2_v = 1'b1; e2_kind = K_FLOAT; end
				M_IDENT: begin e2_v = 1'b1; e2_kind = K_IDENT; end
				default: e2_v = 1'b0;
			endcase
		end

		// A single-byte token and a flush never come from the same byte
		tb_v    = e1_v || e2_v;
		tb_kind = e1_v ? e1_kind : e2_kind;
		tb_len  = e1_v ? pos_t'(1) : e2_len;

		mode_n       = mode_b;
		len_n        = len_b;
		start_line_n = start_line_b;
		start_col_n  = start_col_b;
		line_n       = is_nl ? sat_inc(line_q) : line_q;
		col_n        = is_nl ? '0 : col_inc;
		if (item.last) begin
			mode_n       = M_IDLE;
			len_n        = '0;
			start_line_n = '0;
			start_col_n  = '0;
			line_n       = '0;
			col_n        = '0;
		end
	end

	always_comb begin
		tok_a.token_kind   = e0_kind;
		tok_a.token_line   = clamp_out(start_line_q);
		tok_a.token_column = clamp_out(start_col_q);
		tok_a.token_length = clamp_out(e0_len);
		tok_a.last_of_run  = !tb_v;

		tok_b.token_kind   = tb_kind;
		tok_b.token_line   = clamp_out(start_line_b);
		tok_b.token_column = clamp_out(start_col_b);
		tok_b.token_length = clamp_out(tb_len);
		tok_b.last_of_run  = 1'b1;
	end

	assign tok0    = e0_v ? tok_a : tok_b;
	assign tok1    = tok_b;
	assign tok_wr0 = item_pop && (e0_v || tb_v);
	assign tok_wr1 = item_pop && e0_v && tb_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= M_IDLE;
			line_q       <= '0;
			col_q        <= '0;
			start_line_q <= '0;
			start_col_q  <= '0;
			len_q        <= '0;
		end else if (item_pop) begin
			mode_q       <= mode_n;
			line_q       <= line_n;
			col_q        <= col_n;
			start_line_q <= start_line_n;
			start_col_q  <= start_col_n;
			len_q        <= len_n;
		end
	end

endmodule

@@ rtl/source_token_scanner.sv @@
// Streaming lexical scanner. Source text enters on the in channel, one byte
// per transfer, with end_of_source set on the final byte of a source. Tokens
// leave on the out channel, one per transfer, each with kind, start line,
// start column and length; last_of_run marks the final token that one byte
// caused (a byte causes zero, one or two tokens).
// Throughput: one byte per cycle while the token buffer has room for two
// tokens. The token side moves one token per cycle while out_ready is high,
// so a byte that completes two tokens takes two transfers on the output.
// A byte waits in the byte queue; the first token that it completes is then
// written into the token buffer, and out_valid offers it from there.
// The front classifies bytes into a QUEUE_DEPTH entry queue; the back runs
// the scanner state and takes a byte only while the four-entry token buffer
// has room for two tokens. When the receiver stalls, the token buffer fills,
// the back holds, and in_ready drops once the byte queue is full.
// Reset clears both queues and the scanner: line 0, column 0, nothing
// pending. After a byte with end_of_source the scanner returns to that state.
module source_token_scanner #(
	parameter int POSITION_BITS = 16,
	parameter int QUEUE_DEPTH   = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sts_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output sts_pkg::out_t out_data
);

	import sts_pkg::*;

	localparam int TOK_DEPTH = 4;
	localparam int TOK_CW    = $clog2(TOK_DEPTH + 1);
	localparam int QW        = $bits(item_t);
	localparam int TW        = $bits(out_t);

	item_t                          item_in;
	logic                           push;
	logic [QW-1:0]                  q_rdata;
	logic                           q_empty;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_free;
	logic                           q_pop;

	out_t                           tok0;
	out_t                           tok1;
	logic                           tok_wr0;
	logic                           tok_wr1;
	logic [TW-1:0]                  t_rdata;
	logic                           t_empty;
	logic [TOK_CW-1:0]              t_free;
	logic                           t_room;

	sts_front u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.in_data        (in_data),
		.queue_has_room (q_free != '0),
		.push           (push),
		.item           (item_in)
	);

	sts_fifo #(
		.WIDTH (QW),
		.DEPTH (QUEUE_DEPTH)
	) u_item_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr0    (push),
		.wdata0 (item_in),
		.wr1    (1'b0),
		.wdata1 ('0),
		.rd     (q_pop),
		.rdata  (q_rdata),
		.empty  (q_empty),
		.free   (q_free)
	);

	// Hold the byte until both of its possible tokens fit
	assign t_room = (t_free >= TOK_CW'(2));

	sts_back #(
		.POSITION_BITS (POSITION_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_t'(q_rdata)),
		.item_valid (!q_empty),
		.item_pop   (q_pop),
		.tok_room   (t_room),
		.tok_wr0    (tok_wr0),
		.tok0       (tok0),
		.tok_wr1    (tok_wr1),
		.tok1       (tok1)
	);

	sts_fifo #(
		.WIDTH (TW),
		.DEPTH (TOK_DEPTH)
	) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr0    (tok_wr0),
		.wdata0 (tok0),
		.wr1    (tok_wr1),
		.wdata1 (tok1),
		.rd     (out_valid && out_ready),
		.rdata  (t_rdata),
		.empty  (t_empty),
		.free   (t_free)
	);

	assign out_valid = !t_empty;
	assign out_data  = out_t'(t_rdata);

endmodule

@@ rtl/sts_checker.sv @@
`include "source_token_scanner_defines.svh"

module sts_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input sts_pkg::in_t  in_data,
	input logic          out_valid,
	input logic          out_ready,
	input sts_pkg::out_t out_data
);

	import sts_pkg::*;

	`STS_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(in_data), "input withdrawn or changed before transfer")
	`STS_ASSERT_NEXT(a_out_valid_hold, clk, arst_n, out_valid && !out_ready, out_valid, "out_valid dropped before transfer")
	`STS_ASSERT_NEXT(a_out_data_hold, clk, arst_n, out_valid && !out_ready, $stable(out_data), "out_data changed while stalled")
	`STS_ASSERT_NOW(a_kind_range, clk, arst_n, out_valid, out_data.token_kind <= K_UNTERM, "token kind out of range")
	`STS_ASSERT_NOW(a_pos_nonzero, clk, arst_n, out_valid, (out_data.token_length != '0) && (out_data.token_column != '0), "token with zero length or column")

endmodule

bind source_token_scanner sts_checker u_sts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

@@ tb/sv/token_stream_checker.sv @@
`timescale 1ns / 1ps

module token_stream_checker
	import sts_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_t  in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  out_t out_data,
	output int   failures,
	output int   outstanding
);

	localparam int POS_BITS = 16;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	typedef logic [POS_BITS-1:0] pos_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SLASH,
		S_EQ,
		S_LT,
		S_GT,
		S_BANG,
		S_COMMENT,
		S_STRING,
		S_INT,
		S_FLOAT,
		S_IDENT
	} scan_mode_e;

	scan_mode_e mode;
	pos_t       line_no;
	pos_t       col_no;
	pos_t       tok_line;
	pos_t       tok_col;
	pos_t       lex_len;

	out_t       byte_tokens[$];
	out_t       expected_tokens[$];

	initial failures = 0;

	function automatic pos_t sat_inc(pos_t v);
		return (v == '1) ? v : v + pos_t'(1);
	endfunction

	function automatic logic [OUT_W-1:0] clip(pos_t v);
		logic [31:0] wide;
		logic [31:0] top;
		wide = 32'(v);
		top  = (32'd1 << OUT_W) - 32'd1;
		return (wide > top) ? top[OUT_W-1:0] : wide[OUT_W-1:0];
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic void reset_scan();
		mode     = S_IDLE;
		line_no  = '0;
		col_no   = '0;
		tok_line = '0;
		tok_col  = '0;
		lex_len  = '0;
	endfunction

	function automatic void emit_token(kind_t kind, pos_t len);
		out_t t;
		t.token_kind   = kind;
		t.token_line   = clip(tok_line);
		t.token_column = clip(tok_col);
		t.token_length = clip(len);
		t.last_of_run  = 1'b0;
		byte_tokens.insert(byte_tokens.size(), t);
	endfunction

	function automatic kind_t compare_kind(scan_mode_e m, bit with_eq);
		case (m)
			S_EQ:    return with_eq ? K_EQ_EQ : K_EQ;
			S_LT:    return with_eq ? K_LT_EQ : K_LT;
			S_GT:    return with_eq ? K_GT_EQ : K_GT;
			default: return with_eq ? K_BANG_EQ : K_BANG;
		endcase
	endfunction

	// Scan a byte with nothing pending.
	function automatic void start_token(logic [7:0] b);
		tok_line = line_no;
		tok_col  = col_no;
		lex_len  = pos_t'(1);
		mode     = S_IDLE;
		case (b)
			"(":    emit_token(K_LPAREN, pos_t'(1));
			")":    emit_token(K_RPAREN, pos_t'(1));
			"{":    emit_token(K_LBRACE, pos_t'(1));
			"}":    emit_token(K_RBRACE, pos_t'(1));
			"*":    emit_token(K_STAR, pos_t'(1));
			"+":    emit_token(K_PLUS, pos_t'(1));
			"-":    emit_token(K_MINUS, pos_t'(1));
			".":    emit_token(K_DOT, pos_t'(1));
			",":    emit_token(K_COMMA, pos_t'(1));
			";":    emit_token(K_SEMI, pos_t'(1));
			"/":    mode = S_SLASH;
			"=":    mode = S_EQ;
			"<":    mode = S_LT;
			">":    mode = S_GT;
			"!":    mode = S_BANG;
			"\"":   mode = S_STRING;
			" ", CH_TAB, CH_CR, CH_NL: ;
			default: begin
				if (is_digit(b))
					mode = S_INT;
				else if (is_alpha(b))
					mode = S_IDENT;
				else
					emit_token(K_BAD, pos_t'(1));
			end
		endcase
	endfunction

	function automatic void flush_pending();
		case (mode)
			S_SLASH:                   emit_token(K_SLASH, pos_t'(1));
			S_EQ, S_LT, S_GT, S_BANG:  emit_token(compare_kind(mode, 1'b0), pos_t'(1));
			S_COMMENT:                 emit_token(K_COMMENT, lex_len);
			S_STRING:                  emit_token(K_UNTERM, lex_len);
			S_INT:                     emit_token(K_INT, lex_len);
			S_FLOAT:                   emit_token(K_FLOAT, lex_len);
			S_IDENT:                   emit_token(K_IDENT, lex_len);
			default: ;
		endcase
	endfunction

	function automatic void scan_byte(logic [7:0] b, logic end_src);
		bit rescan;
		rescan = 1'b0;
		byte_tokens.delete();
		if (b != CH_NL)
			col_no = sat_inc(col_no);

		case (mode)
			S_SLASH: begin
				if (b == "/") begin
					mode    = S_COMMENT;
					lex_len = pos_t'(2);
				end else begin
					emit_token(K_SLASH, pos_t'(1));
					rescan = 1'b1;
				end
			end
			S_EQ, S_LT, S_GT, S_BANG: begin
				if (b == "=") begin
					emit_token(compare_kind(mode, 1'b1), pos_t'(2));
					mode = S_IDLE;
				end else begin
					emit_token(compare_kind(mode, 1'b0), pos_t'(1));
					rescan = 1'b1;
				end
			end
			S_COMMENT: begin
				if (b == CH_NL) begin
					emit_token(K_COMMENT, lex_len);
					mode = S_IDLE;
				end else begin
					lex_len = sat_inc(lex_len);
				end
			end
			S_STRING: begin
				lex_len = sat_inc(lex_len);
				if (b == "\"") begin
					emit_token(K_STRING, lex_len);
					mode = S_IDLE;
				end
			end
			S_INT: begin
				if (is_digit(b) || b == "_") begin
					lex_len = sat_inc(lex_len);
				end else if (b == ".") begin
					lex_len = sat_inc(lex_len);
					mode    = S_FLOAT;
				end else begin
					emit_token(K_INT, lex_len);
					rescan = 1'b1;
				end
			end
			S_FLOAT: begin
				if (is_digit(b)) begin
					lex_len = sat_inc(lex_len);
				end else begin
					emit_token(K_FLOAT, lex_len);
					rescan = 1'b1;
				end
			end
			S_IDENT: begin
				if (is_alpha(b) || is_digit(b)) begin
					lex_len = sat_inc(lex_len);
				end else begin
					emit_token(K_IDENT, lex_len);
					rescan = 1'b1;
				end
			end
			default: rescan = 1'b1;
		endcase

		// The byte that ends a lexeme starts the next one.
		if (rescan)
			start_token(b);

		if (b == CH_NL) begin
			line_no = sat_inc(line_no);
			col_no  = '0;
		end

		if (end_src) begin
			flush_pending();
			reset_scan();
		end

		if (byte_tokens.size() != 0)
			byte_tokens[byte_tokens.size()-1].last_of_run = 1'b1;
		foreach (byte_tokens[i])
			expected_tokens.insert(expected_tokens.size(), byte_tokens[i]);
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			reset_scan();
			expected_tokens.delete();
			outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected token: kind %0d line %0d column %0d length %0d",
						out_data.token_kind, out_data.token_line,
						out_data.token_column, out_data.token_length);
					failures++;
				end else begin
					want = expected_tokens.pop_front();
					check_field("token_kind", 32'(want.token_kind),
						32'(out_data.token_kind));
					check_field("token_line", 32'(want.token_line),
						32'(out_data.token_line));
					check_field("token_column", 32'(want.token_column),
						32'(out_data.token_column));
					check_field("token_length", 32'(want.token_length),
						32'(out_data.token_length));
					check_field("last_of_run", 32'(want.last_of_run),
						32'(out_data.last_of_run));
				end
			end
			if (in_valid && in_ready)
				scan_byte(in_data.source_byte, in_data.end_of_source);
			outstanding <= expected_tokens.size();
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import sts_pkg::*;

	localparam int RANDOM_BYTES   = 500;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 8;

	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_NL  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	in_t  in_data;
	logic out_valid;
	logic out_ready;
	out_t out_data;

	int   failures;
	int   outstanding;
	int   idle_cycles;
	bit   no_gaps;

	logic [7:0] text[$];

	source_token_scanner dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	token_stream_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		idle_cycles = 0;
		wait (idle_cycles >= WATCHDOG_LIMIT);
		$display("FAIL");
		$finish;
	end

	function automatic int unsigned draw_gap();
		if (no_gaps || $urandom_range(0, 2) == 0)
			return 0;
		return $urandom_range(1, 18);
	endfunction

	// Token side: drop ready for a random stretch, then hold it until a transfer.
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = draw_gap();
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic end_src);
		int unsigned gap;
		in_t         item;
		gap = draw_gap();
		item.source_byte   = b;
		item.end_of_source = end_src;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic send_text(input bit end_src);
		logic [7:0] b;
		while (text.size() != 0) begin
			b = text.pop_front();
			send_byte(b, end_src && text.size() == 0);
		end
	endtask

	function automatic void add_char(logic [7:0] c);
		text.insert(text.size(), c);
	endfunction

	function automatic void put_str(string s);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i]);
	endfunction

	function automatic logic [7:0] pick(string set);
		return set[$urandom_range(0, set.len() - 1)];
	endfunction

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) :
			8'($urandom_range("A", "Z"));
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'($urandom_range("0", "9"));
	endfunction

	// Append one lexeme with random content; returns 1 for an unclosed string.
	function automatic bit add_lexeme();
		logic [7:0] c;
		int unsigned n;
		bit open_str;
		open_str = 1'b0;
		n = $urandom_range(0, 8);
		case ($urandom_range(0, 9))
			0: add_char(pick("(){}*+-.,;"));
			1: begin
				add_char(pick("=<>!"));
				if ($urandom_range(0, 1))
					add_char("=");
			end
			2: add_char("/");
			3: begin
				put_str("//");
				repeat (n) begin
					c = 8'($urandom_range(0, 255));
					add_char(c == CH_NL ? 8'("x") : c);
				end
				add_char(CH_NL);
			end
			4: begin
				add_char("\"");
				repeat (n) begin
					c = ($urandom_range(0, 5) == 0) ? CH_NL : 8'($urandom_range(32, 126));
					add_char(c == "\"" ? 8'("'") : c);
				end
				if ($urandom_range(0, 5) == 0)
					open_str = 1'b1;
				else
					add_char("\"");
			end
			5: begin
				add_char(rand_digit());
				repeat (n % 6)
					add_char($urandom_range(0, 3) == 0 ? 8'("_") : rand_digit());
			end
			6: begin
				add_char(rand_digit());
				repeat (n % 3)
					add_char(rand_digit());
				add_char(".");
				repeat (n % 4)
					add_char(rand_digit());
			end
			7: begin
				add_char(rand_letter());
				repeat (n % 7)
					add_char($urandom_range(0, 2) == 0 ? rand_digit() : rand_letter());
			end
			8: begin
				case ($urandom_range(0, 4))
					0: add_char(pick("_#@$%^&~`?:"));
					1: add_char(8'h00);
					2: add_char(8'($urandom_range(128, 255)));
					default: add_char(8'($urandom_range(1, 8)));
				endcase
			end
			default: add_char(8'($urandom_range(0, 255)));
		endcase
		return open_str;
	endfunction

	initial begin
		int sent;
		bit end_src;

		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		no_gaps  = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Every single-byte punctuation.
		put_str("(){}*+-.,;");
		send_text(1'b0);
		// Two-byte and one-byte comparisons, slash flushed at end of source.
		put_str("<=>!=/");
		send_text(1'b1);
		// Open string holding a newline, cut off by end of source.
		put_str("\"a");
		add_char(CH_NL);
		put_str("b");
		send_text(1'b1);
		// Lowest and highest byte are bad characters.
		add_char(8'h00);
		add_char(8'hFF);
		send_text(1'b0);
		// Integer with separator turned decimal without a fraction digit.
		put_str("1_.");
		send_text(1'b1);

		sent = 0;
		while (sent < RANDOM_BYTES) begin
			if ($urandom_range(0, 19) == 0)
				no_gaps = ~no_gaps;
			end_src = add_lexeme();
			if (!end_src) begin
				case ($urandom_range(0, 5))
					2: add_char(" ");
					3: add_char(CH_TAB);
					4: add_char(CH_CR);
					5: add_char(CH_NL);
					default: ;
				endcase
				end_src = ($urandom_range(0, 29) == 0);
			end
			sent += text.size();
			send_text(end_src);
		end
		no_gaps = 1'b0;

		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
